/* hdl/jacobi_stencil_sweep_top_macros.svh */
// assertion helpers shared by the jacobi stencil sweep rtl
`ifndef JACOBI_STENCIL_SWEEP_TOP_MACROS_SVH
`define JACOBI_STENCIL_SWEEP_TOP_MACROS_SVH

// same-cycle implication, muted while reset is high
`define JSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, muted while reset is high
`define JSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/jss_pkg.sv */
package jss_pkg;

   localparam int JSS_MAX_WIDTH = 1024;
   localparam int JSS_COL_W     = $clog2(JSS_MAX_WIDTH);
   localparam int JSS_WEFF_W    = JSS_COL_W + 1;
   localparam int JSS_WIDTH_W   = 11;
   localparam int JSS_HEIGHT_W  = 16;
   localparam int JSS_OUT_COL_W = 10;
   localparam int JSS_DATA_W    = 32;
   localparam int JSS_SUM_W     = JSS_DATA_W + 2;
   localparam int JSS_DIFF_W    = JSS_DATA_W + 1;
   localparam int JSS_RES_W     = 64;
   localparam int JSS_CSR_W     = 16;

   localparam int JSS_MIN_SIZE    = 3;
   localparam int JSS_RESET_WIDTH = 1024;
   localparam int JSS_RESET_HEIGHT = 1024;

   typedef enum logic [0:0] {
      JSS_REG_GRID_WIDTH  = 1'b0,
      JSS_REG_GRID_HEIGHT = 1'b1
   } jss_reg_type;

   // per-transaction control carried alongside the data path
   typedef struct packed {
      logic                     emit;
      logic                     last;
      logic                     parity;
      logic [JSS_HEIGHT_W-1:0]  row;
      logic [JSS_OUT_COL_W-1:0] col;
   } jss_ctrl_type;

   typedef struct packed {
      logic [JSS_DATA_W-1:0] port_a;
      logic [JSS_DATA_W-1:0] port_b;
   } jss_bank_rd_type;

endpackage

/* hdl/jss_intf.sv */
interface jss_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [jss_pkg::JSS_DATA_W-1:0] sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink   (input valid, input sample_value, output ready);
endinterface

interface jss_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [jss_pkg::JSS_DATA_W-1:0]    new_value;
   logic [jss_pkg::JSS_HEIGHT_W-1:0]         out_row;
   logic [jss_pkg::JSS_OUT_COL_W-1:0]        out_col;
   logic [jss_pkg::JSS_RES_W-1:0]            residual;
   logic                                     last_of_sweep;

   modport source (output valid, output new_value, output out_row, output out_col,
                   output residual, output last_of_sweep, input ready);
   modport sink   (input valid, input new_value, input out_row, input out_col,
                   input residual, input last_of_sweep, output ready);
endinterface

/* hdl/jss_row_bank.sv */
module jss_row_bank (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [jss_pkg::JSS_COL_W-1:0]   wr_addr,
   input  logic [jss_pkg::JSS_DATA_W-1:0]  wr_data,
   input  logic                            rd_en,
   input  logic [jss_pkg::JSS_COL_W-1:0]   rd_addr_a,
   input  logic [jss_pkg::JSS_COL_W-1:0]   rd_addr_b,
   output jss_pkg::jss_bank_rd_type        rd_data
);
   import jss_pkg::*;

   logic [JSS_DATA_W-1:0] row_mem [JSS_MAX_WIDTH];
   jss_bank_rd_type       rd_data_ff;

   // read sees the old entry when it hits the address written in the same cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff.port_a <= row_mem[rd_addr_a];
         rd_data_ff.port_b <= row_mem[rd_addr_b];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/jss_relax.sv */
module jss_relax (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic signed [jss_pkg::JSS_DATA_W-1:0] in_sample,
   input  jss_pkg::jss_ctrl_type                 in_ctrl,
   input  jss_pkg::jss_bank_rd_type              bank0_rd,
   input  jss_pkg::jss_bank_rd_type              bank1_rd,
   output logic                                  in_ready,
   jss_rsp_if.source                             rsp
);
   import jss_pkg::*;

   // stage valids and enables
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;
   logic s1_en, s2_en, s3_en, s4_en, out_en;

   // stage 1: row store data arrives
   logic signed [JSS_DATA_W-1:0] s1_down_ff;
   jss_ctrl_type                 s1_ctrl_ff;
   logic signed [JSS_DATA_W-1:0] up_val, left_val, right_val;
   logic signed [JSS_SUM_W-1:0]  sum_in;
   logic signed [JSS_DATA_W-1:0] old_ff;

   // stage 2: relaxed value and change
   logic signed [JSS_SUM_W-1:0]  s2_sum_ff;
   logic signed [JSS_DATA_W-1:0] s2_old_ff;
   jss_ctrl_type                 s2_ctrl_ff;
   logic signed [JSS_DATA_W-1:0] relaxed_in;
   logic [JSS_DIFF_W-1:0]        diff_pos, diff_neg;
   logic [JSS_DATA_W-1:0]        mag_in;

   // stage 3: square
   logic signed [JSS_DATA_W-1:0] s3_relaxed_ff;
   logic [JSS_DATA_W-1:0]        s3_mag_ff;
   jss_ctrl_type                 s3_ctrl_ff;

   // stage 4: accumulate
   logic signed [JSS_DATA_W-1:0] s4_relaxed_ff;
   logic [JSS_RES_W-1:0]         s4_sq_ff;
   jss_ctrl_type                 s4_ctrl_ff;
   logic [JSS_RES_W-1:0]         residual_ff, residual_in;
   logic [JSS_RES_W:0]           acc_sum;
   logic [JSS_RES_W-1:0]         acc_sat;

   // output register
   logic signed [JSS_DATA_W-1:0] out_value_ff;
   logic [JSS_HEIGHT_W-1:0]      out_row_ff;
   logic [JSS_OUT_COL_W-1:0]     out_col_ff;
   logic [JSS_RES_W-1:0]         out_residual_ff;
   logic                         out_last_ff;

   assign out_en   = !out_valid_ff || rsp.ready;
   assign s4_en    = !s4_valid_ff || out_en;
   assign s3_en    = !s3_valid_ff || s4_en;
   assign s2_en    = !s2_valid_ff || s3_en;
   assign s1_en    = !s1_valid_ff || s2_en;
   assign in_ready = s1_en;

   // current row bank supplies the point above, the other bank the row being relaxed
   always_comb begin
      if (s1_ctrl_ff.parity) begin
         up_val    = signed'(bank1_rd.port_b);
         left_val  = signed'(bank0_rd.port_b);
         right_val = signed'(bank0_rd.port_a);
      end else begin
         up_val    = signed'(bank0_rd.port_b);
         left_val  = signed'(bank1_rd.port_b);
         right_val = signed'(bank1_rd.port_a);
      end
   end

   assign sum_in = JSS_SUM_W'(up_val) + JSS_SUM_W'(left_val)
                 + JSS_SUM_W'(right_val) + JSS_SUM_W'(s1_down_ff);

   // arithmetic shift gives the floor of the quarter
   assign relaxed_in = s2_sum_ff[JSS_SUM_W-1:2];
   assign diff_pos   = JSS_DIFF_W'(relaxed_in) - JSS_DIFF_W'(s2_old_ff);
   assign diff_neg   = JSS_DIFF_W'(s2_old_ff) - JSS_DIFF_W'(relaxed_in);
   assign mag_in     = diff_pos[JSS_DIFF_W-1] ? diff_neg[JSS_DATA_W-1:0]
                                              : diff_pos[JSS_DATA_W-1:0];

   assign acc_sum = {1'b0, residual_ff} + {1'b0, s4_sq_ff};
   assign acc_sat = acc_sum[JSS_RES_W] ? {JSS_RES_W{1'b1}} : acc_sum[JSS_RES_W-1:0];

   always_comb begin
      residual_in = residual_ff;
      if (s4_valid_ff && out_en) begin
         residual_in = s4_ctrl_ff.last ? '0 : acc_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         residual_ff  <= '0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff && s1_ctrl_ff.emit;
         end
         if (s3_en) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_en) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (out_en) begin
            out_valid_ff <= s4_valid_ff;
         end
         residual_ff <= residual_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en && in_valid) begin
         s1_down_ff <= in_sample;
         s1_ctrl_ff <= in_ctrl;
      end
      // every transaction slides the window, boundary columns included
      if (s1_valid_ff && s2_en) begin
         old_ff     <= right_val;
         s2_sum_ff  <= sum_in;
         s2_old_ff  <= old_ff;
         s2_ctrl_ff <= s1_ctrl_ff;
      end
      if (s2_valid_ff && s3_en) begin
         s3_relaxed_ff <= relaxed_in;
         s3_mag_ff     <= mag_in;
         s3_ctrl_ff    <= s2_ctrl_ff;
      end
      if (s3_valid_ff && s4_en) begin
         s4_relaxed_ff <= s3_relaxed_ff;
         s4_sq_ff      <= JSS_RES_W'(s3_mag_ff) * JSS_RES_W'(s3_mag_ff);
         s4_ctrl_ff    <= s3_ctrl_ff;
      end
      if (s4_valid_ff && out_en) begin
         out_value_ff    <= s4_relaxed_ff;
         out_row_ff      <= s4_ctrl_ff.row;
         out_col_ff      <= s4_ctrl_ff.col;
         out_residual_ff <= s4_ctrl_ff.last ? acc_sat : '0;
         out_last_ff     <= s4_ctrl_ff.last;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.new_value     = out_value_ff;
   assign rsp.out_row       = out_row_ff;
   assign rsp.out_col       = out_col_ff;
   assign rsp.residual      = out_residual_ff;
   assign rsp.last_of_sweep = out_last_ff;

endmodule

/* hdl/jacobi_stencil_sweep_top.sv */
// channel   direction  transaction contents
// req_ch    in         sample_value, one grid point in raster order
// rsp_ch    out        new_value, out_row, out_col, residual, last_of_sweep
// csr       in         csr_wr_en, csr_index, csr_wdata (grid_width, grid_height)
//
// one grid point is taken every cycle while rsp_ch does not stall; a relaxed point leaves
// through stages s1 to s4 and the output register after the point below it is taken.
// the rate is set by the two row banks: each takes one write and two reads a cycle.
// reset is synchronous and clears counters, residual and pipeline valids; the
// row banks are not cleared.
// req_ch.ready drops only in reset, or when all five stages hold points and rsp_ch stalls.
`include "jacobi_stencil_sweep_top_macros.svh"

module jacobi_stencil_sweep_top (
   input  logic                              clock,
   input  logic                              reset,
   jss_req_if.sink                           req_ch,
   jss_rsp_if.source                         rsp_ch,
   input  logic                              csr_wr_en,
   input  jss_pkg::jss_reg_type              csr_index,
   input  logic [jss_pkg::JSS_CSR_W-1:0]     csr_wdata
);
   import jss_pkg::*;

   logic [JSS_WIDTH_W-1:0]  grid_width_ff;
   logic [JSS_HEIGHT_W-1:0] grid_height_ff;
   logic [JSS_WEFF_W-1:0]   width_eff;
   logic [JSS_HEIGHT_W-1:0] height_eff;

   logic [JSS_COL_W-1:0]    col_ff, col_in;
   logic [JSS_HEIGHT_W-1:0] row_ff, row_in;
   logic [JSS_WEFF_W-1:0]   col_inc;
   logic [JSS_HEIGHT_W:0]   row_inc;

   logic                    accept;
   logic                    relax_ready;
   logic                    interior;
   logic                    parity;
   jss_ctrl_type            ctrl;
   jss_bank_rd_type         bank0_rd, bank1_rd;
   logic [JSS_COL_W-1:0]    addr_next, addr_prev;

   // sizes in use
   always_comb begin
      if (grid_width_ff < JSS_WIDTH_W'(JSS_MIN_SIZE)) begin
         width_eff = JSS_WEFF_W'(JSS_MIN_SIZE);
      end else if (JSS_WEFF_W'(grid_width_ff) > JSS_WEFF_W'(JSS_MAX_WIDTH)
                   || grid_width_ff > JSS_WIDTH_W'(JSS_MAX_WIDTH)) begin
         width_eff = JSS_WEFF_W'(JSS_MAX_WIDTH);
      end else begin
         width_eff = JSS_WEFF_W'(grid_width_ff);
      end
      if (grid_height_ff < JSS_HEIGHT_W'(JSS_MIN_SIZE)) begin
         height_eff = JSS_HEIGHT_W'(JSS_MIN_SIZE);
      end else begin
         height_eff = grid_height_ff;
      end
   end

   assign accept = req_ch.valid && req_ch.ready;
   assign parity = row_ff[0];

   assign interior = (row_ff >= JSS_HEIGHT_W'(2)) && (row_ff <= height_eff - 1'b1)
                  && (col_ff != '0) && ({1'b0, col_ff} <= width_eff - JSS_WEFF_W'(2));

   always_comb begin
      ctrl.emit   = interior;
      ctrl.last   = (row_ff == height_eff - 1'b1)
                 && ({1'b0, col_ff} == width_eff - JSS_WEFF_W'(2));
      ctrl.parity = parity;
      ctrl.row    = row_ff - 1'b1;
      ctrl.col    = JSS_OUT_COL_W'(col_ff);
   end

   assign col_inc = {1'b0, col_ff} + 1'b1;
   assign row_inc = {1'b0, row_ff} + 1'b1;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_inc >= width_eff) begin
            col_in = '0;
            row_in = (row_inc >= {1'b0, height_eff}) ? '0 : row_inc[JSS_HEIGHT_W-1:0];
         end else begin
            col_in = col_inc[JSS_COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= JSS_WIDTH_W'(JSS_RESET_WIDTH);
         grid_height_ff <= JSS_HEIGHT_W'(JSS_RESET_HEIGHT);
         col_ff         <= '0;
         row_ff         <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_wr_en) begin
            case (csr_index)
               JSS_REG_GRID_WIDTH:  grid_width_ff  <= csr_wdata[JSS_WIDTH_W-1:0];
               JSS_REG_GRID_HEIGHT: grid_height_ff <= csr_wdata[JSS_HEIGHT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // port a looks one column ahead; port b reads the point above in the
   // current bank and the left neighbour in the other bank
   assign addr_next = col_ff + 1'b1;
   assign addr_prev = col_ff - 1'b1;

   jss_row_bank u_bank0 (
      .clock     (clock),
      .wr_en     (accept && !parity),
      .wr_addr   (col_ff),
      .wr_data   (req_ch.sample_value),
      .rd_en     (accept),
      .rd_addr_a (addr_next),
      .rd_addr_b (parity ? addr_prev : col_ff),
      .rd_data   (bank0_rd)
   );

   jss_row_bank u_bank1 (
      .clock     (clock),
      .wr_en     (accept && parity),
      .wr_addr   (col_ff),
      .wr_data   (req_ch.sample_value),
      .rd_en     (accept),
      .rd_addr_a (addr_next),
      .rd_addr_b (parity ? col_ff : addr_prev),
      .rd_data   (bank1_rd)
   );

   jss_relax u_relax (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_sample (req_ch.sample_value),
      .in_ctrl   (ctrl),
      .bank0_rd  (bank0_rd),
      .bank1_rd  (bank1_rd),
      .in_ready  (relax_ready),
      .rsp       (rsp_ch)
   );

   assign req_ch.ready = relax_ready && !reset;

   `JSS_ASSERT_NOW(a_stall_from_rsp, clock, reset, !req_ch.ready, rsp_ch.valid && !rsp_ch.ready, "input stalled while output is free")
   `JSS_ASSERT_NOW(a_residual_on_last, clock, reset, rsp_ch.valid && !rsp_ch.last_of_sweep, rsp_ch.residual == '0, "residual shown before end of sweep")
   `JSS_ASSERT_NEXT(a_col_step, clock, reset, accept, col_ff == '0 || col_ff == $past(col_ff) + 1'b1, "column counter skipped")

endmodule
